>>> design/sample_autocorrelation_engine_assert.svh
// Assertion macros for the sample autocorrelation engine.
// Used by files that check their own logic; no other dependencies.
`ifndef SAMPLE_AUTOCORRELATION_ENGINE_ASSERT_SVH
`define SAMPLE_AUTOCORRELATION_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define SAE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SAE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SAE_ASSERT_IMP(lbl, ante, cons, msg)
`define SAE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/sac_pkg.sv
// Shared types and constants of the sample autocorrelation engine.
// No dependencies.
package sac_pkg;

    localparam int SAMPLE_W = 32;
    localparam int DEV_W    = 33;
    localparam int MEAN_W   = 33;
    localparam int LAG_W    = 6;
    localparam int CORR_W   = 18;
    localparam int STATUS_W = 2;
    localparam int QUOT_W   = 18;

    localparam logic [LAG_W-1:0] MAX_LAG_RESET = 6'd32;
    localparam logic signed [CORR_W-1:0] CORR_ONE = 18'sd65536;
    localparam logic signed [CORR_W-1:0] CORR_MAX = 18'sd131071;
    localparam logic signed [CORR_W-1:0] CORR_MIN = -18'sd131072;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVF  = 2'd3;

    typedef enum logic [2:0] {
        S_LOAD,
        S_MEAN,
        S_MEAN_WAIT,
        S_STREAM,
        S_FLUSH,
        S_STAT,
        S_LAG,
        S_RATIO_WAIT
    } state_t;

    typedef enum logic [1:0] {
        R_IDLE,
        R_MUL,
        R_CAP,
        R_DIV
    } ratio_state_t;

    typedef struct packed {
        logic clr;
        logic shift;
    } cell_ctrl_t;

endpackage

>>> design/sac_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module sac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/sac_div.sv
// Restoring divider, one quotient bit per cycle.
// Requires num < den * 2**QUO_W. Depends on nothing else.
module sac_div #(
    parameter int NUM_W = 44,
    parameter int DEN_W = 12,
    parameter int QUO_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);

    localparam int CW = $clog2(QUO_W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [QUO_W-1:0] low_reg, low_next;
    logic [QUO_W-1:0] quot_reg, quot_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        trial     = {rem_reg, low_reg[QUO_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(QUO_W);
            rem_next  = DEN_W'(num[NUM_W-1:QUO_W]);
            low_next  = num[QUO_W-1:0];
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = DEN_W'(trial - {1'b0, den_reg});
                quot_next = {quot_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DEN_W-1:0];
                quot_next = {quot_reg[QUO_W-2:0], 1'b0};
            end
            low_next = {low_reg[QUO_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

>>> design/sac_cell.sv
// One lag cell: passes the deviation stream on through one register and accumulates
// head * tap. Depends on sac_pkg.
module sac_cell import sac_pkg::*; #(
    parameter int ACC_W = 76
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctrl_t              ctrl,
    input  logic signed [DEV_W-1:0] head_d,
    input  logic                    head_v,
    input  logic signed [DEV_W-1:0] tap_in_d,
    input  logic                    tap_in_v,
    output logic signed [DEV_W-1:0] tap_out_d,
    output logic                    tap_out_v,
    input  logic signed [ACC_W-1:0] acc_in,
    output logic signed [ACC_W-1:0] acc_out
);

    localparam int PROD_W = 2 * DEV_W;

    logic signed [DEV_W-1:0]  tap_d_reg;
    logic                     tap_v_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_v_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clr)
        begin
            acc_next = '0;
        end
        else if (ctrl.shift)
        begin
            acc_next = acc_in;
        end
        else if (prod_v_reg)
        begin
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            tap_v_reg  <= tap_in_v;
            prod_v_reg <= head_v & tap_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tap_d_reg <= tap_in_d;
        prod_reg  <= head_d * tap_d_reg;
        acc_reg   <= acc_next;
    end

    assign tap_out_d = tap_d_reg;
    assign tap_out_v = tap_v_reg;
    assign acc_out   = acc_reg;

endmodule

>>> design/sac_ratio.sv
// Correlation ratio: round(65536 * P * m_num / (Q * m_den)), saturated.
// Shift-and-add products, then sac_div. Depends on sac_pkg and sac_div.
module sac_ratio import sac_pkg::*; #(
    parameter int ACC_W = 76,
    parameter int CNT_W = 11
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [ACC_W-1:0]  p,
    input  logic [ACC_W-1:0]         q,
    input  logic [CNT_W-1:0]         m_num,
    input  logic [CNT_W-1:0]         m_den,
    output logic                     done,
    output logic signed [CORR_W-1:0] corr
);

    localparam int PN_W = ACC_W + CNT_W;
    localparam int BW   = $clog2(CNT_W);

    ratio_state_t state_reg, state_next;

    logic [ACC_W-1:0] mag_reg, qv_reg;
    logic [CNT_W-1:0] mn_reg, md_reg;
    logic             neg_reg, cap_reg;
    logic [PN_W-1:0]  pn_reg, pd_reg;
    logic [BW-1:0]    bit_reg;
    logic             done_reg;
    logic signed [CORR_W-1:0] corr_reg;

    logic             div_start, div_done;
    logic [QUOT_W-1:0] div_quot;
    logic [PN_W-1:0]  div_rem;
    logic [QUOT_W:0]  qq;

    sac_div #(
        .NUM_W(PN_W + 16),
        .DEN_W(PN_W),
        .QUO_W(QUOT_W)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  ({pn_reg, 16'd0}),
        .den  (pd_reg),
        .done (div_done),
        .quot (div_quot),
        .rem  (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    state_next = R_MUL;
                end
            end
            R_MUL:
            begin
                if (bit_reg == '0)
                begin
                    state_next = R_CAP;
                end
            end
            R_CAP:
            begin
                div_start  = 1'b1;
                state_next = R_DIV;
            end
            R_DIV:
            begin
                if (div_done)
                begin
                    state_next = R_IDLE;
                end
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    // Rounded magnitude; a capped quotient saturates either way.
    always_comb
    begin
        if (cap_reg)
        begin
            qq = {1'b1, {QUOT_W{1'b0}}};
        end
        else
        begin
            qq = {1'b0, div_quot} + (QUOT_W+1)'({div_rem, 1'b0} >= {1'b0, pd_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == R_DIV) && div_done;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            R_IDLE:
            begin
                mag_reg <= p[ACC_W-1] ? ACC_W'(-p) : ACC_W'(p);
                neg_reg <= p[ACC_W-1];
                qv_reg  <= q;
                mn_reg  <= m_num;
                md_reg  <= m_den;
                pn_reg  <= '0;
                pd_reg  <= '0;
                bit_reg <= BW'(CNT_W - 1);
            end
            R_MUL:
            begin
                pn_reg  <= {pn_reg[PN_W-2:0], 1'b0} + (mn_reg[bit_reg] ? PN_W'(mag_reg) : '0);
                pd_reg  <= {pd_reg[PN_W-2:0], 1'b0} + (md_reg[bit_reg] ? PN_W'(qv_reg) : '0);
                bit_reg <= bit_reg - 1'b1;
            end
            R_CAP:
            begin
                cap_reg <= {2'b00, pn_reg, 16'd0} >= {pd_reg, 18'd0};
            end
            R_DIV:
            begin
                if (neg_reg)
                begin
                    if (qq > (QUOT_W+1)'(131072))
                    begin
                        corr_reg <= CORR_MIN;
                    end
                    else
                    begin
                        corr_reg <= CORR_W'(-$signed({1'b0, qq}));
                    end
                end
                else if (qq > (QUOT_W+1)'(131071))
                begin
                    corr_reg <= CORR_MAX;
                end
                else
                begin
                    corr_reg <= CORR_W'(qq);
                end
            end
            default:
            begin
                cap_reg <= cap_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign corr = corr_reg;

endmodule

>>> design/sample_autocorrelation_engine.sv
// Channel  | handshake                        | payload
// input    | start & !busy                    | sample, last
// config   | cfg_valid & cfg_ready            | cfg_data (max_lag)
// result   | result_valid strobe, no stall    | lag, correlation, status, end_of_run
//
// Loading takes one sample beat per cycle. After the last beat the block is busy
// with the mean divider, the store read of all N samples and the lag cell drain,
// then emits lag 0 and, per lag, a result from the shared ratio unit (shift-add
// products and an 18-step divider), or a zero result without it for a lag with
// no work. Reset is asynchronous; max_lag resets to 32.
// The sample store needs no clearing: only entries of the current run are read.
// Depends on sac_pkg, sac_ram, sac_div, sac_cell, sac_ratio and the assertion header.
`include "sample_autocorrelation_engine_assert.svh"

module sample_autocorrelation_engine import sac_pkg::*; #(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_LAG     = 63
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [LAG_W-1:0]           cfg_data,
    output logic                       result_valid,
    output logic [LAG_W-1:0]           lag,
    output logic signed [CORR_W-1:0]   correlation,
    output logic [STATUS_W-1:0]        status,
    output logic                       end_of_run
);

    localparam int AW        = $clog2(MAX_SAMPLES);
    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W     = SAMPLE_W + AW;
    localparam int ACC_W     = 2 * DEV_W + AW;
    localparam int NCELL     = MAX_LAG + 1;
    localparam int FLUSH_LEN = MAX_LAG + 6;
    localparam int FW        = $clog2(FLUSH_LEN);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    ovf_reg, ovf_next;
    logic [LAG_W-1:0]        max_lag_reg;
    logic signed [MEAN_W-1:0] mean_reg, mean_next;
    logic [CNT_W-1:0]        rd_addr_reg, rd_addr_next;
    logic                    rd_v_reg, rd_v_next;
    logic signed [DEV_W-1:0] d_reg, hd_reg;
    logic                    dv_reg, hv_reg;
    logic [FW-1:0]           flush_reg, flush_next;
    logic [ACC_W-1:0]        q_reg, q_next;
    logic [STATUS_W-1:0]     st_reg, st_next, st_calc;
    logic [LAG_W-1:0]        k_reg, k_next, lim;

    logic                     res_v_reg, res_v_next;
    logic [LAG_W-1:0]         lag_reg, lag_next;
    logic signed [CORR_W-1:0] corr_reg, corr_next;
    logic [STATUS_W-1:0]      sto_reg, sto_next;
    logic                     eor_reg, eor_next;

    logic                    accept, ram_we, run_end;
    logic [SAMPLE_W-1:0]     ram_q;
    cell_ctrl_t              cell_ctrl;

    logic signed [SUM_W+1:0] mnum;
    logic [SUM_W:0]          mnum_mag;
    logic                    mdiv_start, mdiv_done;
    logic [31:0]             mdiv_quot;
    logic [CNT_W:0]          mdiv_rem;

    logic                     ratio_start, ratio_done;
    logic signed [CORR_W-1:0] ratio_corr;

    logic signed [DEV_W-1:0] tap_d [NCELL];
    logic                    tap_v [NCELL];
    logic signed [ACC_W-1:0] acc   [NCELL];

    assign accept    = start && (state_reg == S_LOAD);
    assign busy      = (state_reg != S_LOAD);
    assign cfg_ready = (state_reg == S_LOAD);
    assign lim       = (max_lag_reg > LAG_W'(MAX_LAG)) ? LAG_W'(MAX_LAG) : max_lag_reg;

    sac_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(MAX_SAMPLES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(sample),
        .raddr(rd_addr_reg[AW-1:0]),
        .rdata(ram_q)
    );

    // Mean rounded half up: floor((2S + N) / 2N), done on the magnitude.
    assign mnum     = {sum_reg[SUM_W-1], sum_reg, 1'b0} + (SUM_W+2)'(count_reg);
    assign mnum_mag = mnum[SUM_W+1] ? (SUM_W+1)'(-mnum) : (SUM_W+1)'(mnum);

    sac_div #(
        .NUM_W(SUM_W + 1),
        .DEN_W(CNT_W + 1),
        .QUO_W(32)
    ) u_mean_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(mdiv_start),
        .num  (mnum_mag),
        .den  ({count_reg, 1'b0}),
        .done (mdiv_done),
        .quot (mdiv_quot),
        .rem  (mdiv_rem)
    );

    // Cell k sees the head deviation against the one k beats earlier.
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        sac_cell #(
            .ACC_W(ACC_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .head_d   (hd_reg),
            .head_v   (hv_reg),
            .tap_in_d ((i == 0) ? d_reg : tap_d[(i == 0) ? 0 : i - 1]),
            .tap_in_v ((i == 0) ? dv_reg : tap_v[(i == 0) ? 0 : i - 1]),
            .tap_out_d(tap_d[i]),
            .tap_out_v(tap_v[i]),
            .acc_in   ((i == NCELL - 1) ? '0 : acc[(i == NCELL - 1) ? i : i + 1]),
            .acc_out  (acc[i])
        );
    end

    sac_ratio #(
        .ACC_W(ACC_W),
        .CNT_W(CNT_W)
    ) u_ratio (
        .clk  (clk),
        .rst_n(rst_n),
        .start(ratio_start),
        .p    (acc[0]),
        .q    (q_reg),
        .m_num(count_reg - 1'b1),
        .m_den(count_reg - CNT_W'(k_reg)),
        .done (ratio_done),
        .corr (ratio_corr)
    );

    always_comb
    begin
        if (count_reg < CNT_W'(2))
        begin
            st_calc = ST_FEW;
        end
        else if (acc[0] == '0)
        begin
            st_calc = ST_ZERO;
        end
        else if (ovf_reg)
        begin
            st_calc = ST_OVF;
        end
        else
        begin
            st_calc = ST_OK;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        ovf_next     = ovf_reg;
        mean_next    = mean_reg;
        rd_addr_next = rd_addr_reg;
        rd_v_next    = 1'b0;
        flush_next   = flush_reg;
        q_next       = q_reg;
        st_next      = st_reg;
        k_next       = k_reg;
        res_v_next   = 1'b0;
        lag_next     = lag_reg;
        corr_next    = corr_reg;
        sto_next     = sto_reg;
        eor_next     = eor_reg;
        ram_we       = 1'b0;
        mdiv_start   = 1'b0;
        ratio_start  = 1'b0;
        cell_ctrl    = '0;
        run_end      = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg < CNT_W'(MAX_SAMPLES))
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = S_MEAN;
                    end
                end
            end
            S_MEAN:
            begin
                mdiv_start = 1'b1;
                state_next = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (mdiv_done)
                begin
                    if (mnum[SUM_W+1])
                    begin
                        mean_next = -$signed({1'b0, mdiv_quot})
                                    - MEAN_W'(mdiv_rem != '0);
                    end
                    else
                    begin
                        mean_next = $signed({1'b0, mdiv_quot});
                    end
                    rd_addr_next  = '0;
                    cell_ctrl.clr = 1'b1;
                    state_next    = S_STREAM;
                end
            end
            S_STREAM:
            begin
                if (rd_addr_reg < count_reg)
                begin
                    rd_v_next    = 1'b1;
                    rd_addr_next = rd_addr_reg + 1'b1;
                end
                else
                begin
                    flush_next = '0;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                flush_next = flush_reg + 1'b1;
                if (flush_reg == FW'(FLUSH_LEN - 1))
                begin
                    state_next = S_STAT;
                end
            end
            S_STAT:
            begin
                // Lag zero is always 1.0; the chain then moves lag one to the head.
                q_next          = acc[0];
                st_next         = st_calc;
                res_v_next      = 1'b1;
                lag_next        = '0;
                corr_next       = CORR_ONE;
                sto_next        = st_calc;
                eor_next        = (lim == '0);
                cell_ctrl.shift = 1'b1;
                k_next          = LAG_W'(1);
                if (lim == '0)
                begin
                    run_end = 1'b1;
                end
                else
                begin
                    state_next = S_LAG;
                end
            end
            S_LAG:
            begin
                if (st_reg == ST_FEW || st_reg == ST_ZERO
                    || 32'(k_reg) >= 32'(count_reg))
                begin
                    res_v_next      = 1'b1;
                    lag_next        = k_reg;
                    corr_next       = '0;
                    sto_next        = st_reg;
                    eor_next        = (k_reg == lim);
                    cell_ctrl.shift = 1'b1;
                    k_next          = k_reg + 1'b1;
                    if (k_reg == lim)
                    begin
                        run_end = 1'b1;
                    end
                end
                else
                begin
                    ratio_start = 1'b1;
                    state_next  = S_RATIO_WAIT;
                end
            end
            S_RATIO_WAIT:
            begin
                if (ratio_done)
                begin
                    res_v_next      = 1'b1;
                    lag_next        = k_reg;
                    corr_next       = ratio_corr;
                    sto_next        = st_reg;
                    eor_next        = (k_reg == lim);
                    cell_ctrl.shift = 1'b1;
                    k_next          = k_reg + 1'b1;
                    if (k_reg == lim)
                    begin
                        run_end = 1'b1;
                    end
                    else
                    begin
                        state_next = S_LAG;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (run_end)
        begin
            count_next = '0;
            sum_next   = '0;
            ovf_next   = 1'b0;
            state_next = S_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            sum_reg     <= '0;
            ovf_reg     <= 1'b0;
            max_lag_reg <= MAX_LAG_RESET;
            rd_addr_reg <= '0;
            rd_v_reg    <= 1'b0;
            dv_reg      <= 1'b0;
            hv_reg      <= 1'b0;
            flush_reg   <= '0;
            st_reg      <= ST_OK;
            k_reg       <= '0;
            res_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            ovf_reg     <= ovf_next;
            if (cfg_valid && cfg_ready)
            begin
                max_lag_reg <= cfg_data;
            end
            rd_addr_reg <= rd_addr_next;
            rd_v_reg    <= rd_v_next;
            dv_reg      <= rd_v_reg;
            hv_reg      <= dv_reg;
            flush_reg   <= flush_next;
            st_reg      <= st_next;
            k_reg       <= k_next;
            res_v_reg   <= res_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
        d_reg    <= DEV_W'({{2{ram_q[SAMPLE_W-1]}}, ram_q} - {mean_reg[MEAN_W-1], mean_reg});
        hd_reg   <= d_reg;
        q_reg    <= q_next;
        lag_reg  <= lag_next;
        corr_reg <= corr_next;
        sto_reg  <= sto_next;
        eor_reg  <= eor_next;
    end

    assign result_valid = res_v_reg;
    assign lag          = lag_reg;
    assign correlation  = corr_reg;
    assign status       = sto_reg;
    assign end_of_run   = eor_reg;

    `SAE_ASSERT_NXT(a_last_starts_run, start && !busy && last, busy,
                    "last beat did not start a run")
    `SAE_ASSERT_IMP(a_lag0_is_one, result_valid && lag == '0, correlation == CORR_ONE,
                    "lag zero not 1.0")
    `SAE_ASSERT_IMP(a_bad_status_zero,
                    result_valid && lag != '0 && (status == ST_FEW || status == ST_ZERO),
                    correlation == '0, "nonzero correlation with bad status")
    `SAE_ASSERT_NXT(a_end_then_quiet, result_valid && end_of_run, !result_valid,
                    "result after end of run")
    `SAE_ASSERT_IMP(a_read_in_range, state_reg == S_STREAM, rd_addr_reg <= count_reg,
                    "store read past fill")

endmodule
